>>> design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Types, constants and calendar helpers for the cron schedule matcher.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int unsigned FIRST_YEAR = 1970;
	localparam int unsigned LAST_YEAR  = 2099;

	typedef enum logic [1:0] {
		ACT_SET_CLOCK = 2'd0,
		ACT_WRITE     = 2'd1,
		ACT_TICK      = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		SEL_MINUTE  = 3'd0,
		SEL_HOUR    = 3'd1,
		SEL_DAY     = 3'd2,
		SEL_MONTH   = 3'd3,
		SEL_WEEKDAY = 3'd4
	} mask_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WDAY  = 2'd1,
		ST_SCAN  = 2'd2,
		ST_EMPTY = 2'd3
	} state_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  weekday;
	} cal_t;

	// one entry's masks, in value order (day and month bit 0 means value 1)
	typedef struct packed {
		logic [59:0] minute;
		logic [23:0] hour;
		logic [30:0] day;
		logic [11:0] month;
		logic [6:0]  weekday;
	} masks_t;

	// write command handed down the chain of cells
	typedef struct packed {
		logic        en;
		logic [5:0]  index;
		mask_sel_t   sel;
		logic [59:0] bits;
	} wr_t;

	function automatic logic [4:0] days_in(input logic [11:0] year, input logic [3:0] month);
		logic [4:0] len;
		case (month)
			4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// weekday offset (mod 7) of the first of a month within its year
	function automatic logic [2:0] month_off(input logic leap, input logic [3:0] month);
		logic [2:0] o;
		case (month)
			4'd1:    o = 3'd0;
			4'd2:    o = 3'd3;
			4'd3:    o = leap ? 3'd4 : 3'd3;
			4'd4:    o = leap ? 3'd0 : 3'd6;
			4'd5:    o = leap ? 3'd2 : 3'd1;
			4'd6:    o = leap ? 3'd5 : 3'd4;
			4'd7:    o = leap ? 3'd0 : 3'd6;
			4'd8:    o = leap ? 3'd3 : 3'd2;
			4'd9:    o = leap ? 3'd6 : 3'd5;
			4'd10:   o = leap ? 3'd1 : 3'd0;
			4'd11:   o = leap ? 3'd4 : 3'd3;
			4'd12:   o = leap ? 3'd6 : 3'd5;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

	function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
	endfunction

	// remainder by 7 of a day offset (0..31), one compare and subtract
	function automatic logic [2:0] mod7_small(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (r >= 5'd28)      r = r - 5'd28;
		else if (r >= 5'd21) r = r - 5'd21;
		else if (r >= 5'd14) r = r - 5'd14;
		else if (r >= 5'd7)  r = r - 5'd7;
		return r[2:0];
	endfunction

endpackage

>>> design/csm_if.sv
// ----------------------------------------------------------------------------
// csm_in_if / csm_out_if
// Valid/ready channels for commands and match results.
// ----------------------------------------------------------------------------
interface csm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  entry_index;
	logic [2:0]  mask_select;
	logic [59:0] mask_bits;
	logic [11:0] set_year;
	logic [3:0]  set_month;
	logic [4:0]  set_day;
	logic [4:0]  set_hour;
	logic [5:0]  set_minute;
	modport source (output valid, action, entry_index, mask_select, mask_bits,
		set_year, set_month, set_day, set_hour, set_minute, input ready);
	modport sink (input valid, action, entry_index, mask_select, mask_bits,
		set_year, set_month, set_day, set_hour, set_minute, output ready);
endinterface

interface csm_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [3:0]  entry_number;
	logic        last;
	logic [11:0] time_year;
	logic [3:0]  time_month;
	logic [4:0]  time_day;
	logic [4:0]  time_hour;
	logic [5:0]  time_minute;
	logic [2:0]  time_weekday;
	modport source (output valid, hit, entry_number, last, time_year, time_month,
		time_day, time_hour, time_minute, time_weekday, input ready);
	modport sink (input valid, hit, entry_number, last, time_year, time_month,
		time_day, time_hour, time_minute, time_weekday, output ready);
endinterface

>>> design/csm_cell.sv
// ----------------------------------------------------------------------------
// csm_cell
// One table entry: holds its masks, passes writes and the token onward.
// ----------------------------------------------------------------------------
module csm_cell import csm_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  wr_t    wr_in,
	output wr_t    wr_out,
	input  logic   adv,          // scan step: chain shifts one place
	input  logic   load,         // load match bit for the current time
	input  cal_t   now,
	input  logic   match_in,     // match flag from the upstream neighbor
	output logic   match_out
);
	masks_t masks_q;
	wr_t    wr_q;
	logic   match_q;
	logic   ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= '0;
			wr_q    <= '0;
			match_q <= 1'b0;
		end else begin
			wr_q <= wr_in;
			if (wr_in.en && wr_in.index == 6'(IDX)) begin
				case (wr_in.sel)
					SEL_MINUTE:  masks_q.minute  <= wr_in.bits;
					SEL_HOUR:    masks_q.hour    <= wr_in.bits[23:0];
					SEL_DAY:     masks_q.day     <= wr_in.bits[31:1];
					SEL_MONTH:   masks_q.month   <= wr_in.bits[12:1];
					SEL_WEEKDAY: masks_q.weekday <= wr_in.bits[6:0];
					default: ;
				endcase
			end
			if (load)
				match_q <= ok;
			else if (adv)
				match_q <= match_in;
		end
	end

	assign ok = masks_q.minute[now.minute] && masks_q.hour[now.hour]
		&& masks_q.day[5'(now.day - 5'd1)] && masks_q.month[4'(now.month - 4'd1)]
		&& masks_q.weekday[now.weekday];

	assign wr_out    = wr_q;
	assign match_out = match_q;
endmodule

>>> design/csm_clock.sv
// ----------------------------------------------------------------------------
// csm_clock
// Calendar register: set with clamping, weekday by yearly walk, tick advance.
// ----------------------------------------------------------------------------
module csm_clock import csm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        set_en,
	input  logic [11:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hour,
	input  logic [5:0]  set_minute,
	input  logic        advance,
	output logic        wday_busy,
	output cal_t        now
);
	cal_t       cal_q;
	logic [11:0] walk_q;     // year being walked toward cal_q.year
	logic [2:0]  acc_q;      // weekday of Jan 1 of walk_q
	logic        busy_q;
	logic [11:0] y;
	logic [3:0]  mo;
	logic [4:0]  d, len, h;
	logic [5:0]  mi;
	logic        at_end;
	cal_t        nxt;

	always_comb begin
		y  = (set_year < 12'(FIRST_YEAR)) ? 12'(FIRST_YEAR) :
			(set_year > 12'(LAST_YEAR)) ? 12'(LAST_YEAR) : set_year;
		mo = (set_month < 4'd1) ? 4'd1 : (set_month > 4'd12) ? 4'd12 : set_month;
		len = days_in(y, mo);
		d  = (set_day < 5'd1) ? 5'd1 : (set_day > len) ? len : set_day;
		h  = (set_hour > 5'd23) ? 5'd23 : set_hour;
		mi = (set_minute > 6'd59) ? 6'd59 : set_minute;
	end

	always_comb begin
		nxt = cal_q;
		at_end = cal_q.year >= 12'(LAST_YEAR) && cal_q.month == 4'd12 && cal_q.day == 5'd31
			&& cal_q.hour == 5'd23 && cal_q.minute == 6'd59;
		if (!at_end) begin
			if (cal_q.minute != 6'd59) nxt.minute = cal_q.minute + 6'd1;
			else begin
				nxt.minute = '0;
				if (cal_q.hour != 5'd23) nxt.hour = cal_q.hour + 5'd1;
				else begin
					nxt.hour = '0;
					nxt.weekday = add_mod7(cal_q.weekday, 3'd1);
					if (cal_q.day < days_in(cal_q.year, cal_q.month))
						nxt.day = cal_q.day + 5'd1;
					else begin
						nxt.day = 5'd1;
						if (cal_q.month < 4'd12) nxt.month = cal_q.month + 4'd1;
						else begin
							nxt.month = 4'd1;
							nxt.year  = cal_q.year + 12'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= '{year: 12'(FIRST_YEAR), month: 4'd1, day: 5'd1, hour: '0,
				minute: '0, weekday: 3'd4};
			walk_q <= 12'(FIRST_YEAR);
			acc_q  <= 3'd4;
			busy_q <= 1'b0;
		end else if (set_en) begin
			cal_q  <= '{year: y, month: mo, day: d, hour: h, minute: mi, weekday: '0};
			walk_q <= 12'(FIRST_YEAR);
			acc_q  <= 3'd4;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			// one year per cycle: 365 = 1, 366 = 2 mod 7
			if (walk_q != cal_q.year) begin
				acc_q  <= add_mod7(acc_q, (walk_q[1:0] == 2'b00) ? 3'd2 : 3'd1);
				walk_q <= walk_q + 12'd1;
			end else begin
				cal_q.weekday <= add_mod7(add_mod7(acc_q,
					month_off(cal_q.year[1:0] == 2'b00, cal_q.month)),
					mod7_small(cal_q.day - 5'd1));
				busy_q <= 1'b0;
			end
		end else if (advance) begin
			cal_q <= nxt;
		end
	end

	assign wday_busy = busy_q;
	assign now = cal_q;
endmodule

>>> design/cron_schedule_matcher_unit.sv
// ----------------------------------------------------------------------------
// cron_schedule_matcher_unit
// Minute calendar clock with a chain of cron entry cells.
// ----------------------------------------------------------------------------
// channel  dir  transfer
// cmd      in   set clock / write mask / tick
// res      out  one per matching entry, or one miss, last on the final
// cfg      in   entry_count, write enable only
//
// A mask write ripples down the chain one cell a cycle; input stays closed
// while the write is still in the chain so a following tick sees it in every cell.
// Set clock walks the years from 1970 for the weekday; input stays closed meanwhile.
// A tick loads match flags, then shifts them out one cell a cycle while the
// output is not stalled. Reset clears all masks.
module cron_schedule_matcher_unit import csm_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	csm_in_if.sink     cmd,
	csm_out_if.source  res
);
	localparam int unsigned N   = MAX_ENTRIES;
	localparam int unsigned CW  = $clog2(N + 1);
	localparam int unsigned EFF = (N < 16) ? N : 16;

	logic [4:0]    count_q;
	state_t        state_q, state_d;
	logic [CW-1:0] pos_q;     // index of entry at chain head
	logic [CW-1:0] lim;       // active entries
	logic          any_q;
	logic          ev_valid_q;
	logic          tail_q;
	logic [3:0]    tnum_q;
	logic [N-1:0]  wr_pend;   // a write still moving down the chain
	logic          ofree, acc, do_tick, do_set, step, last_step, wday_busy;
	cal_t          now, snap_q;
	wr_t           wr_chain [N+1];
	logic          m_chain  [N+1];

	assign lim = (count_q > 5'(EFF)) ? CW'(EFF) : CW'(count_q);
	assign ofree   = !ev_valid_q || res.ready;
	assign cmd.ready = state_q == ST_IDLE && !wday_busy && !tail_q && !(|wr_pend);
	assign acc     = cmd.valid && cmd.ready;
	assign do_tick = acc && action_t'(cmd.action) == ACT_TICK;
	assign do_set  = acc && action_t'(cmd.action) == ACT_SET_CLOCK;
	assign step    = state_q == ST_SCAN && ofree;
	assign last_step = pos_q + CW'(1) >= lim;

	assign wr_chain[0] = '{en: acc && action_t'(cmd.action) == ACT_WRITE,
		index: 6'(cmd.entry_index), sel: mask_sel_t'(cmd.mask_select), bits: cmd.mask_bits};
	assign m_chain[N] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		csm_cell #(.IDX(i)) u_cell (
			.clk, .arst_n, .wr_in(wr_chain[i]), .wr_out(wr_chain[i+1]),
			.adv(step), .load(do_tick), .now,
			.match_in(m_chain[i+1]), .match_out(m_chain[i]));
		assign wr_pend[i] = wr_chain[i+1].en;
	end

	csm_clock u_clock (
		.clk, .arst_n, .set_en(do_set), .set_year(cmd.set_year),
		.set_month(cmd.set_month), .set_day(cmd.set_day), .set_hour(cmd.set_hour),
		.set_minute(cmd.set_minute), .advance(do_tick), .wday_busy, .now);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (do_tick) state_d = (lim == '0) ? ST_EMPTY : ST_SCAN;
			ST_SCAN:  if (step && last_step && (any_q || m_chain[0])) state_d = ST_IDLE;
				else if (step && last_step) state_d = ST_EMPTY;
			ST_EMPTY: if (ofree) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			any_q    <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			state_q <= state_d;
			if (do_tick) begin
				pos_q <= '0;
				any_q <= 1'b0;
			end else if (step) begin
				pos_q <= pos_q + CW'(1);
				if (m_chain[0]) any_q <= 1'b1;
			end
		end
	end

	// hits are held one behind so the final one can be flagged last
	logic [3:0]  pnum_q;
	always_ff @(posedge clk) begin
		if (do_tick) snap_q <= now;
		if (step && m_chain[0]) pnum_q <= 4'(pos_q);
	end
	// output register
	logic        ohit_q, olast_q;
	logic [3:0]  onum_q;
	cal_t        otime_q;
	logic        held_q;   // a hit waits for its successor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) held_q <= 1'b0;
		else begin
			if (do_tick) held_q <= 1'b0;
			else if (step && m_chain[0]) held_q <= 1'b1;
			else if (step && last_step) held_q <= 1'b0;
		end
	end
	logic emit;
	assign emit = (step && ((m_chain[0] && held_q) || (last_step && (held_q || m_chain[0]))))
		|| (state_q == ST_EMPTY && ofree);
	logic        ev_hit, ev_last;
	logic [3:0]  ev_num;
	// pending-tail: a new hit on the last step still needs one more slot
	always_comb begin
		ev_hit = 1'b1; ev_last = 1'b0; ev_num = pnum_q;
		if (state_q == ST_EMPTY) begin
			ev_hit = 1'b0; ev_last = 1'b1; ev_num = '0;
		end else if (last_step && !m_chain[0]) begin
			ev_last = 1'b1;
		end else if (last_step && m_chain[0] && !held_q) begin
			ev_num = 4'(pos_q); ev_last = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (emit || tail_q && ofree) begin
			ohit_q  <= tail_q ? 1'b1 : ev_hit;
			olast_q <= tail_q ? 1'b1 : ev_last;
			onum_q  <= tail_q ? tnum_q : ev_num;
			otime_q <= snap_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0; ev_valid_q <= 1'b0; tnum_q <= '0;
		end else begin
			if (tail_q && ofree) tail_q <= 1'b0;
			if (step && last_step && m_chain[0] && held_q) begin
				tail_q <= 1'b1; tnum_q <= 4'(pos_q);
			end
			if (res.ready) ev_valid_q <= 1'b0;
			if (emit || (tail_q && ofree)) ev_valid_q <= 1'b1;
		end
	end

	assign res.valid        = ev_valid_q;
	assign res.hit          = ohit_q;
	assign res.entry_number = onum_q;
	assign res.last         = olast_q;
	assign res.time_year    = otime_q.year;
	assign res.time_month   = otime_q.month;
	assign res.time_day     = otime_q.day;
	assign res.time_hour    = otime_q.hour;
	assign res.time_minute  = otime_q.minute;
	assign res.time_weekday = otime_q.weekday;

	assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (state_q == ST_IDLE)) else $error("command taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |-> res.last) else $error("miss not last");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (pos_q < lim)) else $error("scan past count");
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the cron schedule matcher against a calendar and mask-table model:
// directed table, then random clock sets, mask writes and ticks under
// several idle/stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import csm_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic        hit;
		logic [3:0]  entry_number;
		logic        last;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  weekday;
	} match_t;

	typedef struct {
		action_t     act;
		logic [3:0]  idx;
		logic [2:0]  sel;
		logic [59:0] bits;
		logic [11:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mi;
		bit          has_exp;
		match_t      exp_res;
	} cmd_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;

	csm_in_if  cmd();
	csm_out_if res();

	cron_schedule_matcher_unit #(.MAX_ENTRIES(16)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd(cmd.sink), .res(res.source)
	);

	// model state
	int unsigned m_year, m_month, m_day, m_hour, m_minute, m_wday;
	logic [59:0] m_min_mask [16];
	logic [23:0] m_hr_mask [16];
	logic [30:0] m_day_mask [16];
	logic [11:0] m_mon_mask [16];
	logic [6:0]  m_wd_mask [16];
	int unsigned m_count;

	match_t pending_matches[$];
	int     n_errors;
	int     n_cycles;
	int     send_idle_pct, recv_stall_pct;
	bit     hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		n_cycles = 0;
		forever begin
			@(posedge clk);
			n_cycles++;
			if (n_cycles > LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		int unsigned lens[12];
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && y % 4 == 0)
			return 29;
		return lens[(m - 1) % 12];
	endfunction

	function automatic int unsigned weekday_from_epoch(int unsigned y, int unsigned m,
			int unsigned d);
		int unsigned sum;
		sum = 0;
		for (int unsigned k = FIRST_YEAR; k < y; k++)
			sum += (k % 4 == 0) ? 366 : 365;
		for (int unsigned k = 1; k < m; k++)
			sum += month_days(y, k);
		sum += d - 1;
		return (4 + sum) % 7;
	endfunction

	function automatic match_t stamp(logic h, logic [3:0] e, logic l);
		match_t r;
		r = '{h, e, l, m_year[11:0], m_month[3:0], m_day[4:0], m_hour[4:0],
			m_minute[5:0], m_wday[2:0]};
		return r;
	endfunction

	function automatic void advance_minute();
		if (m_year >= LAST_YEAR && m_month == 12 && m_day == 31 && m_hour == 23 &&
				m_minute == 59)
			return;
		m_minute++;
		if (m_minute < 60) return;
		m_minute = 0;
		m_hour++;
		if (m_hour < 24) return;
		m_hour = 0;
		m_wday = (m_wday + 1) % 7;
		if (m_day < month_days(m_year, m_month)) begin
			m_day++;
			return;
		end
		m_day = 1;
		if (m_month < 12) begin
			m_month++;
			return;
		end
		m_month = 1;
		m_year++;
	endfunction

	// applies one command to the model, queues the matches it yields
	function automatic void predict_matches(cmd_row_t c);
		int unsigned y, mo, d, h, mi, n, k;
		bit ok;
		case (c.act)
			ACT_SET_CLOCK: begin
				y = c.yr; mo = c.mo; d = c.dy; h = c.hr; mi = c.mi;
				if (y < FIRST_YEAR) y = FIRST_YEAR;
				if (y > LAST_YEAR) y = LAST_YEAR;
				if (mo < 1) mo = 1;
				if (mo > 12) mo = 12;
				if (d < 1) d = 1;
				if (d > month_days(y, mo)) d = month_days(y, mo);
				if (h > 23) h = 23;
				if (mi > 59) mi = 59;
				m_year = y; m_month = mo; m_day = d; m_hour = h; m_minute = mi;
				m_wday = weekday_from_epoch(y, mo, d);
			end
			ACT_WRITE: begin
				case (c.sel)
					SEL_MINUTE:  m_min_mask[c.idx] = c.bits;
					SEL_HOUR:    m_hr_mask[c.idx] = c.bits[23:0];
					SEL_DAY:     m_day_mask[c.idx] = c.bits[31:1];
					SEL_MONTH:   m_mon_mask[c.idx] = c.bits[12:1];
					SEL_WEEKDAY: m_wd_mask[c.idx] = c.bits[6:0];
					default: ;
				endcase
			end
			ACT_TICK: begin
				n = (m_count > 16) ? 16 : m_count;
				k = 0;
				for (int unsigned i = 0; i < n; i++) begin
					ok = m_min_mask[i][m_minute] && m_hr_mask[i][m_hour] &&
						m_day_mask[i][m_day - 1] && m_mon_mask[i][m_month - 1] &&
						m_wd_mask[i][m_wday];
					if (ok) begin
						pending_matches.insert(pending_matches.size(),
							stamp(1'b1, i[3:0], 1'b0));
						k++;
					end
				end
				if (k == 0)
					pending_matches.insert(pending_matches.size(),
						stamp(1'b0, 4'd0, 1'b1));
				else
					pending_matches[$].last = 1'b1;
				advance_minute();
			end
			default: ;
		endcase
	endfunction

	// sender
	task automatic send_cmd(cmd_row_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= c.act;
		cmd.entry_index <= c.idx;
		cmd.mask_select <= c.sel;
		cmd.mask_bits <= c.bits;
		cmd.set_year <= c.yr;
		cmd.set_month <= c.mo;
		cmd.set_day <= c.dy;
		cmd.set_hour <= c.hr;
		cmd.set_minute <= c.mi;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		// transfer happened at this edge
		predict_matches(c);
		if (c.has_exp && pending_matches.size() > 0) begin
			if (pending_matches[$] !== c.exp_res)
				note_error(c.exp_res, pending_matches[$]);
		end
	endtask

	task automatic note_error(match_t exp_v, match_t act_v);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch: expected %p got %p", exp_v, act_v);
	endtask

	// receiver and checker
	initial begin
		match_t got, want;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				got = '{res.hit, res.entry_number, res.last, res.time_year,
					res.time_month, res.time_day, res.time_hour, res.time_minute,
					res.time_weekday};
				if (pending_matches.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected transfer %p", got);
				end else begin
					want = pending_matches.pop_front();
					if (got !== want)
						note_error(want, got);
				end
			end
			res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// leaves the block with nothing in flight
	task automatic wait_drain();
		cmd.valid <= 1'b0;
		while (pending_matches.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	task automatic write_count(int unsigned v);
		cfg_we <= 1'b1;
		cfg_wdata <= v[4:0];
		m_count = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic cmd_row_t mk(action_t a, int unsigned idx, int unsigned sel,
			logic [59:0] bits, int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi);
		cmd_row_t c;
		c = '{a, idx[3:0], sel[2:0], bits, y[11:0], mo[3:0], d[4:0], h[4:0],
			mi[5:0], 1'b0, '0};
		return c;
	endfunction

	function automatic cmd_row_t with_exp(cmd_row_t c, match_t r);
		c.has_exp = 1'b1;
		c.exp_res = r;
		return c;
	endfunction

	function automatic cmd_row_t rand_cmd(int unsigned n_ent);
		cmd_row_t c;
		int unsigned r;
		logic [59:0] b;
		r = $urandom_range(99);
		b = 60'({$urandom, $urandom});
		if ($urandom_range(3) == 0)
			b = {60{1'b1}};
		if (r < 10) begin
			c = mk(ACT_SET_CLOCK, 0, 0, b, $urandom_range(FIRST_YEAR, LAST_YEAR),
				$urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
				$urandom_range(0, 59));
			if ($urandom_range(9) == 0) begin
				c.yr = 12'($urandom); c.mo = 4'($urandom); c.dy = 5'($urandom);
				c.hr = 5'($urandom); c.mi = 6'($urandom);
			end else if ($urandom_range(3) == 0) begin
				c.hr = 5'd23; c.mi = 6'($urandom_range(57, 59));
				c.dy = 5'(month_days(c.yr, c.mo));
			end
		end else if (r < 45) begin
			c = mk(ACT_WRITE, $urandom_range(n_ent - 1), $urandom_range(4), b,
				0, 0, 0, 0, 0);
			if ($urandom_range(9) == 0) begin
				c.sel = 3'($urandom);
				c.idx = 4'($urandom);
			end
		end else if (r < 97) begin
			c = mk(ACT_TICK, $urandom, $urandom, b, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			c = mk(ACT_NONE, $urandom, $urandom, b, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end
		return c;
	endfunction

	initial begin
		cmd_row_t dir_rows[$];
		int unsigned idle_mix[4][2];
		int unsigned cnt_mix[4];
		logic [59:0] all1;
		all1 = {60{1'b1}};
		idle_mix = '{'{0, 0}, '{65, 0}, '{0, 65}, '{24, 24}};
		cnt_mix = '{16, 3, 31, 8};
		n_errors = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.action = ACT_NONE;
		cmd.entry_index = '0;
		cmd.mask_select = '0;
		cmd.mask_bits = '0;
		cmd.set_year = '0;
		cmd.set_month = '0;
		cmd.set_day = '0;
		cmd.set_hour = '0;
		cmd.set_minute = '0;
		m_year = FIRST_YEAR; m_month = 1; m_day = 1; m_hour = 0; m_minute = 0;
		m_wday = 4; m_count = 0;
		for (int i = 0; i < 16; i++) begin
			m_min_mask[i] = '0; m_hr_mask[i] = '0; m_day_mask[i] = '0;
			m_mon_mask[i] = '0; m_wd_mask[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_rows.insert(dir_rows.size(), with_exp(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
			'{1'b0, 4'd0, 1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 3'd4}));
		for (int s = 0; s < 5; s++)
			dir_rows.insert(dir_rows.size(), mk(ACT_WRITE, 0, s, all1, 0, 0, 0, 0, 0));
		for (int s = 0; s < 5; s++)
			dir_rows.insert(dir_rows.size(), mk(ACT_WRITE, 15, s, all1, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_WRITE, 15, 3'd7, '0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_WRITE, 3, SEL_DAY, 60'h1, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_NONE, 0, 0, all1, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_SET_CLOCK, 0, 0, 0, 2099, 12, 31, 23, 59));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_SET_CLOCK, 0, 0, 0, 4095, 15, 31, 31, 63));
		dir_rows.insert(dir_rows.size(), mk(ACT_SET_CLOCK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_SET_CLOCK, 0, 0, 0, 2000, 2, 30, 23, 59));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_SET_CLOCK, 0, 0, 0, 1999, 12, 31, 23, 59));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));

		write_count(16);
		foreach (dir_rows[i])
			send_cmd(dir_rows[i]);
		wait_drain();
		write_count(0);
		send_cmd(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		wait_drain();

		// random phases
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p][0];
			recv_stall_pct = idle_mix[p][1];
			write_count(cnt_mix[p]);
			for (int i = 0; i < 48; i++) begin
				if (p == 0 && i == 10)
					hold_off = 1'b1;
				send_cmd(rand_cmd(16));
			end
			wait_drain();
		end
		repeat (50) @(posedge clk);
		if (n_errors == 0 && pending_matches.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// long output hold-off while the sender keeps offering commands
	initial begin
		int unsigned held;
		wait (hold_off);
		held = 0;
		while (held < 300) begin
			@(posedge clk);
			held++;
		end
		hold_off = 1'b0;
	end

endmodule

>>> sim.f
design/csm_pkg.sv
design/csm_if.sv
design/csm_cell.sv
design/csm_clock.sv
design/cron_schedule_matcher_unit.sv
tb/tb_top.sv
